// File: rtl/eight_bit_cpu_execute_subset_unit_macros.svh
// ---------------------------------------------------------------------------
// eight_bit_cpu_execute_subset_unit assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_EXECUTE_SUBSET_UNIT_MACROS_SVH
`define EIGHT_BIT_CPU_EXECUTE_SUBSET_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ECSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecsu check failed");
// next-cycle implication
`define ECSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecsu check failed");
`else
`define ECSU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ECSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ecsu_pkg.sv
// ---------------------------------------------------------------------------
// ecsu_pkg
// shared types and constants of the execute subset unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ecsu_pkg;
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam logic [7:0] HIGH_PAGE = 8'hFF;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_EXEC, S_ACC2, S_FIN
    } t_state;

    // unprefixed opcodes
    localparam logic [7:0] OP_NOP = 8'h00, OP_LD_BC = 8'h01, OP_LD_DE = 8'h11,
        OP_LD_HL = 8'h21, OP_LD_SP = 8'h31, OP_LD_A_DE = 8'h1A, OP_LD_HLI = 8'h22,
        OP_LD_HLD = 8'h32, OP_LD_M16 = 8'hEA, OP_LD_B_N = 8'h06, OP_LD_C_N = 8'h0E,
        OP_LD_D_N = 8'h16, OP_LD_E_N = 8'h1E, OP_LD_A_N = 8'h3E, OP_LD_C_A = 8'h4F,
        OP_LD_D_A = 8'h57, OP_LD_H_A = 8'h67, OP_LD_M_A = 8'h77, OP_LD_A_B = 8'h78,
        OP_LD_A_E = 8'h7B, OP_LD_A_H = 8'h7C, OP_LD_A_L = 8'h7D, OP_LDH_N_A = 8'hE0,
        OP_LDH_C_A = 8'hE2, OP_LDH_A_N = 8'hF0, OP_INC_B = 8'h04, OP_INC_C = 8'h0C,
        OP_INC_H = 8'h24, OP_DEC_B = 8'h05, OP_DEC_C = 8'h0D, OP_DEC_D = 8'h15,
        OP_DEC_E = 8'h1D, OP_DEC_A = 8'h3D, OP_INC_DE = 8'h13, OP_INC_HL = 8'h23,
        OP_RLA = 8'h17, OP_JR = 8'h18, OP_JR_NZ = 8'h20, OP_JR_Z = 8'h28,
        OP_ADD_M = 8'h86, OP_SUB_B = 8'h90, OP_XOR_A = 8'hAF, OP_CP_M = 8'hBE,
        OP_CP_N = 8'hFE, OP_POP_BC = 8'hC1, OP_PUSH_BC = 8'hC5, OP_RET = 8'hC9,
        OP_PREFIX = 8'hCB, OP_CALL = 8'hCD;
    // prefixed opcodes
    localparam logic [7:0] CB_RL_C = 8'h11, CB_BIT7_H = 8'h7C;
endpackage

// File: rtl/eight_bit_cpu_execute_subset_unit.sv
// ---------------------------------------------------------------------------
// eight_bit_cpu_execute_subset_unit
// executes one instruction of an 8-bit accumulator cpu subset per input word
// ---------------------------------------------------------------------------
// Each input word carries an opcode and the two bytes after it; each one
// yields exactly one output word with next pc, cycle cost, A, F and status.
// After reset the unit first zeroes its 2**MEM_ADDR_BITS byte data memory,
// one byte per clock, with s_tready low. An instruction then passes the steps
// accept, first memory access, second memory access and finish; the two
// access steps serve the single-port data memory, which push, pop, call and
// ret use twice. A finished result sits in the output register while the
// next word is already accepted and executed.
`timescale 1ns / 1ps
`include "eight_bit_cpu_execute_subset_unit_macros.svh"
module eight_bit_cpu_execute_subset_unit #(
    parameter int MEM_ADDR_BITS = ecsu_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // opcode [7:0], imm_low [15:8], imm_high [23:16]
    input  logic [ecsu_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // next_pc [15:0], cycle_count [21:16], acc_value [29:22],
    // flag_bits [37:30], status [38], zero pad [39]
    output logic [ecsu_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import ecsu_pkg::*;

    // flag byte: z n h c in the high nibble, low nibble kept
    function automatic logic [7:0] mk_flags(logic [7:0] f, logic z, logic n,
                                            logic h, logic c);
        mk_flags = {z, n, h, c, f[3:0]};
    endfunction

    function automatic logic [7:0] sub_flags(logic [7:0] f, logic [7:0] a,
                                             logic [7:0] b);
        sub_flags = mk_flags(f, a == b, 1'b1, a[3:0] < b[3:0], a < b);
    endfunction

    t_state r_state, n_state;

    // architectural registers
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0]  n_a, n_f, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [15:0] r_sp, n_sp, r_pc;
    logic        r_pre, n_pre;

    // captured instruction and first read byte
    logic [7:0]  r_op, r_lo, r_hi, r_d1;
    logic [MEM_ADDR_BITS-1:0] r_clr;

    // output register
    logic        r_ov;
    logic [OUT_DATA_W-1:0] r_odata;

    // memory port
    logic        w_en, w_we;
    logic [15:0] w_addr;
    logic [7:0]  w_wdata, w_rdata;

    logic        w_accept, w_fin_go, w_ok, w_take;
    logic [15:0] w_imm16, w_hl, w_de, w_pc3, w_next, w_rel;
    logic [5:0]  w_cyc;
    logic [1:0]  w_len;
    logic [7:0]  w_v, w_r;
    logic [8:0]  w_sum;

    assign w_imm16 = {r_hi, r_lo};
    assign w_hl    = {r_h, r_l};
    assign w_de    = {r_d, r_e};
    assign w_pc3   = r_pc + 16'd3;
    assign w_rel   = {{8{r_lo[7]}}, r_lo};

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fin_go = (r_state == S_FIN) && (!r_ov || i_m_axis_tready);

    ecsu_ram #(
        .P_WIDTH(8),
        .P_DEPTH(2 ** MEM_ADDR_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_we   (w_we),
        .i_addr (w_addr[MEM_ADDR_BITS-1:0]),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (&r_clr) n_state = S_IDLE;
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: n_state = S_ACC2;
            S_ACC2: n_state = S_FIN;
            S_FIN:  if (w_fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
    end

    // memory access per step: clear sweep, then the first and second access
    always_comb begin
        w_en    = 1'b0;
        w_we    = 1'b0;
        w_addr  = w_hl;
        w_wdata = r_a;
        if (r_state == S_CLR) begin
            w_en    = 1'b1;
            w_we    = 1'b1;
            w_addr  = 16'(r_clr);
            w_wdata = 8'h00;
        end else if (r_state == S_EXEC && !r_pre) begin
            unique case (r_op) inside
                OP_LD_HLI, OP_LD_HLD, OP_LD_M_A: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = w_hl;
                end
                OP_LD_M16: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = w_imm16;
                end
                OP_LDH_N_A: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = {HIGH_PAGE, r_lo};
                end
                OP_LDH_C_A: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = {HIGH_PAGE, r_c};
                end
                OP_PUSH_BC: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = r_sp - 16'd1; w_wdata = r_b;
                end
                OP_CALL: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = r_sp - 16'd1;
                    w_wdata = w_pc3[15:8];
                end
                OP_LD_A_DE:        begin w_en = 1'b1; w_addr = w_de; end
                OP_ADD_M, OP_CP_M: begin w_en = 1'b1; w_addr = w_hl; end
                OP_LDH_A_N:        begin w_en = 1'b1; w_addr = {HIGH_PAGE, r_lo}; end
                OP_POP_BC, OP_RET: begin w_en = 1'b1; w_addr = r_sp; end
                default: ;
            endcase
        end else if (r_state == S_ACC2 && !r_pre) begin
            unique case (r_op) inside
                OP_PUSH_BC: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = r_sp - 16'd2; w_wdata = r_c;
                end
                OP_CALL: begin
                    w_en = 1'b1; w_we = 1'b1; w_addr = r_sp - 16'd2;
                    w_wdata = w_pc3[7:0];
                end
                OP_POP_BC, OP_RET: begin w_en = 1'b1; w_addr = r_sp + 16'd1; end
                default: ;
            endcase
        end
    end

    // execute: new register values, cost and next pc
    always_comb begin
        n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c;
        n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_sp = r_sp; n_pre = r_pre;
        w_ok = 1'b1; w_len = 2'd1; w_cyc = 6'd4;
        w_v = 8'h00; w_r = 8'h00; w_sum = 9'h000; w_take = 1'b1;
        w_next = r_pc + 16'd1;
        if (r_pre) begin
            unique case (r_op) inside
                CB_RL_C: begin
                    w_r = {r_c[6:0], r_f[4]};
                    n_c = w_r;
                    n_f = mk_flags(r_f, w_r == 8'h00, 1'b0, 1'b0, r_c[7]);
                end
                CB_BIT7_H: n_f = mk_flags(r_f, !r_h[7], 1'b0, 1'b1, r_f[4]);
                default: w_ok = 1'b0;
            endcase
            if (w_ok) n_pre = 1'b0;
        end else begin
            unique case (r_op) inside
                OP_NOP: ;
                OP_LD_BC: begin {n_b, n_c} = w_imm16; w_len = 2'd3; w_cyc = 6'd16; end
                OP_LD_DE: begin {n_d, n_e} = w_imm16; w_len = 2'd3; w_cyc = 6'd16; end
                OP_LD_HL: begin {n_h, n_l} = w_imm16; w_len = 2'd3; w_cyc = 6'd16; end
                OP_LD_SP: begin n_sp = w_imm16; w_len = 2'd3; w_cyc = 6'd16; end
                OP_LD_A_DE: begin n_a = r_d1; w_cyc = 6'd8; end
                OP_LD_HLI: begin {n_h, n_l} = w_hl + 16'd1; w_cyc = 6'd8; end
                OP_LD_HLD: begin {n_h, n_l} = w_hl - 16'd1; w_cyc = 6'd8; end
                OP_LD_M16: begin w_len = 2'd3; w_cyc = 6'd16; end
                OP_LD_B_N: begin n_b = r_lo; w_len = 2'd2; w_cyc = 6'd8; end
                OP_LD_C_N: begin n_c = r_lo; w_len = 2'd2; w_cyc = 6'd8; end
                OP_LD_D_N: begin n_d = r_lo; w_len = 2'd2; w_cyc = 6'd8; end
                OP_LD_E_N: begin n_e = r_lo; w_len = 2'd2; w_cyc = 6'd8; end
                OP_LD_A_N: begin n_a = r_lo; w_len = 2'd2; w_cyc = 6'd8; end
                OP_LD_C_A: n_c = r_a;
                OP_LD_D_A: n_d = r_a;
                OP_LD_H_A: n_h = r_a;
                OP_LD_A_B: n_a = r_b;
                OP_LD_A_E: n_a = r_e;
                OP_LD_A_H: n_a = r_h;
                OP_LD_A_L: n_a = r_l;
                OP_LD_M_A: w_cyc = 6'd8;
                OP_LDH_N_A: begin w_len = 2'd2; w_cyc = 6'd12; end
                OP_LDH_C_A: w_cyc = 6'd8;
                OP_LDH_A_N: begin n_a = r_d1; w_len = 2'd2; w_cyc = 6'd12; end
                OP_INC_B, OP_INC_C, OP_INC_H: begin
                    w_v = (r_op == OP_INC_B) ? r_b : ((r_op == OP_INC_C) ? r_c : r_h);
                    w_r = w_v + 8'd1;
                    if (r_op == OP_INC_B) n_b = w_r;
                    else if (r_op == OP_INC_C) n_c = w_r;
                    else n_h = w_r;
                    n_f = mk_flags(r_f, w_r == 8'h00, 1'b0, w_v[3:0] == 4'hF, r_f[4]);
                end
                OP_DEC_B, OP_DEC_C, OP_DEC_D, OP_DEC_E, OP_DEC_A: begin
                    case (r_op)
                        OP_DEC_B: w_v = r_b;
                        OP_DEC_C: w_v = r_c;
                        OP_DEC_D: w_v = r_d;
                        OP_DEC_E: w_v = r_e;
                        default:  w_v = r_a;
                    endcase
                    w_r = w_v - 8'd1;
                    case (r_op)
                        OP_DEC_B: n_b = w_r;
                        OP_DEC_C: n_c = w_r;
                        OP_DEC_D: n_d = w_r;
                        OP_DEC_E: n_e = w_r;
                        default:  n_a = w_r;
                    endcase
                    n_f = mk_flags(r_f, w_r == 8'h00, 1'b1, w_v[3:0] == 4'h0, r_f[4]);
                end
                OP_INC_DE: begin {n_d, n_e} = w_de + 16'd1; w_cyc = 6'd8; end
                OP_INC_HL: begin {n_h, n_l} = w_hl + 16'd1; w_cyc = 6'd8; end
                OP_RLA: begin
                    n_a = {r_a[6:0], r_f[4]};
                    n_f = mk_flags(r_f, 1'b0, 1'b0, 1'b0, r_a[7]);
                end
                OP_JR, OP_JR_NZ, OP_JR_Z: begin
                    if (r_op == OP_JR_Z) w_take = r_f[7];
                    else if (r_op == OP_JR_NZ) w_take = !r_f[7];
                    w_cyc = w_take ? 6'd12 : 6'd8;
                    w_len = 2'd0;
                    w_next = r_pc + 16'd2 + (w_take ? w_rel : 16'h0000);
                end
                OP_ADD_M: begin
                    w_sum = {1'b0, r_a} + {1'b0, r_d1};
                    n_a = w_sum[7:0];
                    n_f = mk_flags(r_f, w_sum[7:0] == 8'h00, 1'b0,
                                   ({1'b0, r_a[3:0]} + {1'b0, r_d1[3:0]}) > 5'h0F,
                                   w_sum[8]);
                    w_cyc = 6'd8;
                end
                OP_SUB_B: begin n_a = r_a - r_b; n_f = sub_flags(r_f, r_a, r_b); end
                OP_XOR_A: begin
                    n_a = 8'h00;
                    n_f = mk_flags(r_f, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                OP_CP_M: begin n_f = sub_flags(r_f, r_a, r_d1); w_cyc = 6'd8; end
                OP_CP_N: begin
                    n_f = sub_flags(r_f, r_a, r_lo); w_len = 2'd2; w_cyc = 6'd8;
                end
                OP_POP_BC: begin
                    {n_b, n_c} = {w_rdata, r_d1}; n_sp = r_sp + 16'd2; w_cyc = 6'd12;
                end
                OP_PUSH_BC: begin n_sp = r_sp - 16'd2; w_cyc = 6'd16; end
                OP_RET: begin
                    w_next = {w_rdata, r_d1}; w_len = 2'd0;
                    n_sp = r_sp + 16'd2; w_cyc = 6'd16;
                end
                OP_PREFIX: n_pre = 1'b1;
                OP_CALL: begin
                    n_sp = r_sp - 16'd2; w_next = w_imm16; w_len = 2'd0; w_cyc = 6'd24;
                end
                default: w_ok = 1'b0;
            endcase
            if (w_len != 2'd0) w_next = r_pc + 16'(w_len);
        end
        // unimplemented: pc held, no cost, nothing else changed
        if (!w_ok) begin
            w_next = r_pc;
            w_cyc  = 6'd0;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_a <= 8'h00; r_f <= 8'h00; r_b <= 8'h00; r_c <= 8'h00;
            r_d <= 8'h00; r_e <= 8'h00; r_h <= 8'h00; r_l <= 8'h00;
            r_sp  <= 16'h0000;
            r_pc  <= 16'h0000;
            r_pre <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (w_fin_go) begin
                r_ov <= 1'b1;
                r_pc <= w_next;
                if (w_ok) begin
                    r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c;
                    r_d <= n_d; r_e <= n_e; r_h <= n_h; r_l <= n_l;
                    r_sp <= n_sp; r_pre <= n_pre;
                end
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_s_axis_tdata[7:0];
            r_lo <= i_s_axis_tdata[15:8];
            r_hi <= i_s_axis_tdata[23:16];
        end
        // first read byte comes back from the registered ram read in the cycle after the first access
        if (r_state == S_ACC2) r_d1 <= w_rdata;
        if (w_fin_go) begin
            r_odata <= {1'b0, !w_ok, (w_ok ? n_f : r_f), (w_ok ? n_a : r_a),
                        w_cyc, w_next};
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    // memory is touched only by the sweep and the two access steps
    `ECSU_ASSERT_NOW(a_mem_step, i_clk, i_rst_n, w_en,
        r_state == S_CLR || r_state == S_EXEC || r_state == S_ACC2)
    // an accepted word goes straight to its first access
    `ECSU_ASSERT_NEXT(a_acc_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC)
    // finish waits while the previous result is still held
    `ECSU_ASSERT_NEXT(a_fin_hold, i_clk, i_rst_n,
        r_state == S_FIN && r_ov && !i_m_axis_tready, r_state == S_FIN)
    // error words cost no cycles
    `ECSU_ASSERT_NOW(a_err_cyc, i_clk, i_rst_n, r_ov && r_odata[38],
        r_odata[21:16] == 6'd0)
endmodule

// File: rtl/ecsu_ram.sv
// ---------------------------------------------------------------------------
// ecsu_ram
// single-port synchronous ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ecsu_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule
